>>> rtl/core/lmim_pkg.sv
// Shared types, codes and fixed widths of the LED matrix index mapper.
package lmim_pkg;

    // Fixed field widths.
    localparam int IDX_W  = 10;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;
    localparam int OP_W   = 2;
    localparam int MODE_W = 3;
    localparam int REGI_W = 3;

    // The divider works on an 11-bit position and an 11-bit divisor.
    localparam int DIV_W   = 11;
    localparam int DIV_CNT_W = 4;

    // The shared multiplier takes two 11-bit operands.
    localparam int MUL_W  = 11;
    localparam int PROD_W = 2 * MUL_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Layout codes.
    localparam logic [MODE_W-1:0] LAYOUT_ROW_H    = 3'd0;
    localparam logic [MODE_W-1:0] LAYOUT_ROW_V    = 3'd1;
    localparam logic [MODE_W-1:0] LAYOUT_ZIGZAG_H = 3'd2;
    localparam logic [MODE_W-1:0] LAYOUT_ZIGZAG_V = 3'd3;
    localparam logic [MODE_W-1:0] LAYOUT_TABLE    = 3'd4;

    // Configuration register indexes.
    localparam logic [REGI_W-1:0] REG_STRIP_LENGTH   = 3'd0;
    localparam logic [REGI_W-1:0] REG_BASE_INDEX     = 3'd1;
    localparam logic [REGI_W-1:0] REG_STEP_SIZE      = 3'd2;
    localparam logic [REGI_W-1:0] REG_REVERSE_DIR    = 3'd3;
    localparam logic [REGI_W-1:0] REG_VIRTUAL_LENGTH = 3'd4;
    localparam logic [REGI_W-1:0] REG_MATRIX_ROWS    = 3'd5;
    localparam logic [REGI_W-1:0] REG_MATRIX_COLS    = 3'd6;
    localparam logic [REGI_W-1:0] REG_LAYOUT_MODE    = 3'd7;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLAMP,
        ST_DIV,
        ST_MUL2,
        ST_COMBINE,
        ST_TBL_RD,
        ST_TBL_WAIT,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/lmim_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module lmim_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lmim_pkg::DIV_W-1:0]    dividend,
    input  logic [lmim_pkg::DIV_W-1:0]    divisor,
    output logic [lmim_pkg::DIV_W-1:0]    quotient,
    output logic [lmim_pkg::DIV_W-1:0]    remainder,
    output logic                          done
);

    localparam int W = lmim_pkg::DIV_W;

    logic [W-1:0]                   quo_reg;
    logic [W-1:0]                   rem_reg;
    logic [W-1:0]                   den_reg;
    logic [lmim_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [W:0]                     trial;
    logic [W:0]                     diff;
    logic                           fits;

    // The trial remainder brings down the next dividend bit.
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= lmim_pkg::DIV_CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lmim_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> rtl/core/lmim_table.sv
// Store of user-defined physical LED indices with a registered read port.
module lmim_table
#(
    parameter int DEPTH = 1024
)
(
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(DEPTH)-1:0]       waddr,
    input  logic [lmim_pkg::POS_W-1:0]     wdata,
    input  logic                           re,
    input  logic [$clog2(DEPTH)-1:0]       raddr,
    output logic [lmim_pkg::POS_W-1:0]     rdata
);

    logic [lmim_pkg::POS_W-1:0] mem [DEPTH];
    logic [lmim_pkg::POS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/led_matrix_index_mapper_core.sv
// LED matrix index mapper: virtual to physical LED index with layout remap.
// From acceptance to result the vertical layouts pass multiply, clamp, the shared divider,
// a second multiply and combine; zigzag horizontal skips the second multiply, row horizontal
// stops after the clamp, a table hit reads and waits on the table, and any other transaction
// goes straight to the result. One transaction at a time, the next taken in the cycle after
// the result is loaded; a stalled result holds the sequencer in its last state.
module led_matrix_index_mapper_core
#(
    parameter int MAX_LEDS = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [lmim_pkg::REGI_W-1:0]     cfg_index,
    input  logic [lmim_pkg::CFG_W-1:0]      cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lmim_pkg::OP_W-1:0]       operation,
    input  logic [lmim_pkg::IDX_W-1:0]      index,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lmim_pkg::POS_W-1:0]      position,
    output logic                            in_range,
    output logic                            accepted
);

    // Reset is asynchronous and active low; the configuration registers take their documented
    // defaults and the table fill is 0.

    // Width of the fill count, which must reach MAX_LEDS itself, and of a table address.
    localparam int FILL_W = $clog2(MAX_LEDS + 1);
    localparam int ADDR_W = $clog2(MAX_LEDS);
    // Common width for comparing the fill with the strip length and the index.
    localparam int CMP_W  = (FILL_W > lmim_pkg::CFG_W) ? FILL_W : lmim_pkg::CFG_W;

    localparam int CW = lmim_pkg::CFG_W;
    localparam int PW = lmim_pkg::POS_W;

    // Configuration registers.
    logic [CW-1:0]                 strip_length_reg;
    logic [PW-1:0]                 base_index_reg;
    logic [PW-1:0]                 step_size_reg;
    logic                          reverse_dir_reg;
    logic [CW-1:0]                 virtual_length_reg;
    logic [CW-1:0]                 matrix_rows_reg;
    logic [CW-1:0]                 matrix_cols_reg;
    logic [lmim_pkg::MODE_W-1:0]   layout_mode_reg;

    // Sequencer and working registers.
    lmim_pkg::state_t              state_reg, state_next;
    logic [lmim_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic [lmim_pkg::PROD_W-1:0]   mul_reg;
    logic [CW-1:0]                 v_reg, v_next;
    logic [PW-1:0]                 res_pos_reg, res_pos_next;
    logic                          res_inr_reg, res_inr_next;
    logic                          res_acc_reg, res_acc_next;

    // Output register, which frees the sequencer while a result waits.
    logic                          out_valid_reg, out_valid_next;
    logic [PW-1:0]                 position_reg;
    logic                          in_range_reg;
    logic                          accepted_reg;
    logic                          out_load;

    // Shared multiplier.
    logic                          mul_en;
    logic [lmim_pkg::MUL_W-1:0]    mul_a;
    logic [lmim_pkg::MUL_W-1:0]    mul_b;

    // Divider interface.
    logic                          div_start;
    logic [CW-1:0]                 div_divisor;
    logic [CW-1:0]                 div_quo;
    logic [CW-1:0]                 div_rem;
    logic                          div_done;

    // Table interface.
    logic                          tbl_we;
    logic                          tbl_re;
    logic [PW-1:0]                 tbl_rdata;
    logic [CMP_W-1:0]              idx_cmp;
    logic [CMP_W-1:0]              idx_reg_cmp;
    logic [CMP_W-1:0]              fill_cmp;
    logic                          table_mode;
    logic                          can_append;
    logic                          table_hit;

    // Clamp datapath.
    logic [CW-1:0]                 last_led;
    logic [lmim_pkg::PROD_W-1:0]   base_ext;
    logic [lmim_pkg::PROD_W-1:0]   lin_pos;
    logic [CW-1:0]                 v_clamped;
    logic                          needs_div;

    // Layout remap operands (zero rows or columns count as one).
    logic [CW-1:0]                 rows_eff;
    logic [CW-1:0]                 cols_eff;
    logic                          odd_row_vert;
    logic [PW-1:0]                 q10;
    logic [PW-1:0]                 r10;
    logic [PW-1:0]                 c10;
    logic [PW-1:0]                 p10;

    // ---------------------------------------------------------------------
    // Configuration port. The user must write registers only while no
    // transaction is in flight; the block itself does not enforce this.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg   <= CW'(1024);
            base_index_reg     <= '0;
            step_size_reg      <= PW'(1);
            reverse_dir_reg    <= 1'b0;
            virtual_length_reg <= '0;
            matrix_rows_reg    <= CW'(1);
            matrix_cols_reg    <= CW'(1024);
            layout_mode_reg    <= lmim_pkg::LAYOUT_ROW_H;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lmim_pkg::REG_STRIP_LENGTH:   strip_length_reg   <= cfg_data;
                lmim_pkg::REG_BASE_INDEX:     base_index_reg     <= cfg_data[PW-1:0];
                lmim_pkg::REG_STEP_SIZE:      step_size_reg      <= cfg_data[PW-1:0];
                lmim_pkg::REG_REVERSE_DIR:    reverse_dir_reg    <= cfg_data[0];
                lmim_pkg::REG_VIRTUAL_LENGTH: virtual_length_reg <= cfg_data;
                lmim_pkg::REG_MATRIX_ROWS:    matrix_rows_reg    <= cfg_data;
                lmim_pkg::REG_MATRIX_COLS:    matrix_cols_reg    <= cfg_data;
                lmim_pkg::REG_LAYOUT_MODE:    layout_mode_reg    <= cfg_data[lmim_pkg::MODE_W-1:0];
                default:                      strip_length_reg   <= strip_length_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Table bookkeeping. An append needs room both on the strip and in the
    // store; a map only reads entries below the fill, which were all written.
    // ---------------------------------------------------------------------
    assign table_mode  = (layout_mode_reg == lmim_pkg::LAYOUT_TABLE);
    assign fill_cmp    = CMP_W'(fill_reg);
    assign idx_cmp     = CMP_W'(index);
    assign idx_reg_cmp = CMP_W'(idx_reg);
    assign can_append  = (fill_cmp < CMP_W'(strip_length_reg))
                      && (fill_cmp < CMP_W'(MAX_LEDS));
    assign table_hit   = (idx_cmp < fill_cmp) && (idx_cmp < CMP_W'(MAX_LEDS));

    // ---------------------------------------------------------------------
    // Linear position and clamp. Forward sums past the strip end and reverse
    // underflows both land on the last LED.
    // ---------------------------------------------------------------------
    assign last_led = (strip_length_reg == '0) ? '0 : strip_length_reg - 1'b1;
    assign base_ext = lmim_pkg::PROD_W'(base_index_reg);

    always_comb
    begin
        if (reverse_dir_reg)
        begin
            if (mul_reg > base_ext)
            begin
                lin_pos = lmim_pkg::PROD_W'(last_led);
            end
            else
            begin
                lin_pos = base_ext - mul_reg;
            end
        end
        else
        begin
            lin_pos = base_ext + mul_reg;
        end

        if (lin_pos >= lmim_pkg::PROD_W'(strip_length_reg))
        begin
            v_clamped = last_led;
        end
        else
        begin
            v_clamped = lin_pos[CW-1:0];
        end
    end

    always_comb
    begin
        unique case (layout_mode_reg) inside
            lmim_pkg::LAYOUT_ROW_V, lmim_pkg::LAYOUT_ZIGZAG_H,
            lmim_pkg::LAYOUT_ZIGZAG_V: needs_div = 1'b1;
            default:                   needs_div = 1'b0;
        endcase
    end

    assign rows_eff    = (matrix_rows_reg == '0) ? CW'(1) : matrix_rows_reg;
    assign cols_eff    = (matrix_cols_reg == '0) ? CW'(1) : matrix_cols_reg;
    // Zigzag horizontal folds on columns; the vertical layouts split on rows.
    assign div_divisor = (layout_mode_reg == lmim_pkg::LAYOUT_ZIGZAG_H) ? cols_eff : rows_eff;

    // An odd row of the vertical zigzag runs backwards.
    assign odd_row_vert = (layout_mode_reg == lmim_pkg::LAYOUT_ZIGZAG_V) && div_rem[0];

    // The remap only keeps the low position bits, so it works modulo 2^10.
    assign q10 = div_quo[PW-1:0];
    assign r10 = div_rem[PW-1:0];
    assign c10 = cols_eff[PW-1:0];
    assign p10 = mul_reg[PW-1:0];

    // ---------------------------------------------------------------------
    // Sequencer: next state and the working values.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        v_next         = v_reg;
        res_pos_next   = res_pos_reg;
        res_inr_next   = res_inr_reg;
        res_acc_next   = res_acc_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        tbl_we         = 1'b0;
        tbl_re         = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            lmim_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next     = index;
                    res_pos_next = '0;
                    res_inr_next = 1'b0;
                    res_acc_next = 1'b0;
                    state_next   = lmim_pkg::ST_FINISH;
                    case (operation)
                        lmim_pkg::OP_MAP:
                        begin
                            if (table_mode)
                            begin
                                if (table_hit)
                                begin
                                    res_inr_next = 1'b1;
                                    state_next   = lmim_pkg::ST_TBL_RD;
                                end
                                else
                                begin
                                    res_pos_next = index;
                                end
                            end
                            else
                            begin
                                res_inr_next = (CW'(index) < virtual_length_reg);
                                state_next   = lmim_pkg::ST_MUL;
                            end
                        end
                        lmim_pkg::OP_APPEND:
                        begin
                            if (table_mode && can_append)
                            begin
                                tbl_we       = 1'b1;
                                fill_next    = fill_reg + 1'b1;
                                res_acc_next = 1'b1;
                            end
                        end
                        lmim_pkg::OP_CLEAR:
                        begin
                            if (table_mode)
                            begin
                                fill_next    = '0;
                                res_acc_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_acc_next = 1'b0;
                        end
                    endcase
                end
            end

            lmim_pkg::ST_TBL_RD:
            begin
                tbl_re     = 1'b1;
                state_next = lmim_pkg::ST_TBL_WAIT;
            end

            lmim_pkg::ST_TBL_WAIT:
            begin
                res_pos_next = tbl_rdata;
                state_next   = lmim_pkg::ST_FINISH;
            end

            lmim_pkg::ST_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = lmim_pkg::MUL_W'(step_size_reg);
                mul_b      = lmim_pkg::MUL_W'(idx_reg);
                state_next = lmim_pkg::ST_CLAMP;
            end

            lmim_pkg::ST_CLAMP:
            begin
                v_next = v_clamped;
                if (needs_div)
                begin
                    div_start  = 1'b1;
                    state_next = lmim_pkg::ST_DIV;
                end
                else
                begin
                    res_pos_next = v_clamped[PW-1:0];
                    state_next   = lmim_pkg::ST_FINISH;
                end
            end

            lmim_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (layout_mode_reg == lmim_pkg::LAYOUT_ZIGZAG_H)
                    begin
                        state_next = lmim_pkg::ST_COMBINE;
                    end
                    else
                    begin
                        state_next = lmim_pkg::ST_MUL2;
                    end
                end
            end

            lmim_pkg::ST_MUL2:
            begin
                mul_en     = 1'b1;
                mul_a      = cols_eff;
                mul_b      = odd_row_vert ? div_rem + 1'b1 : div_rem;
                state_next = lmim_pkg::ST_COMBINE;
            end

            lmim_pkg::ST_COMBINE:
            begin
                if (layout_mode_reg == lmim_pkg::LAYOUT_ZIGZAG_H)
                begin
                    if (div_quo[0])
                    begin
                        res_pos_next = v_reg[PW-1:0] + c10 - {r10[PW-2:0], 1'b0} - PW'(1);
                    end
                    else
                    begin
                        res_pos_next = v_reg[PW-1:0];
                    end
                end
                else if (odd_row_vert)
                begin
                    res_pos_next = p10 - PW'(1) - q10;
                end
                else
                begin
                    res_pos_next = q10 + p10;
                end
                state_next = lmim_pkg::ST_FINISH;
            end

            lmim_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lmim_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lmim_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmim_pkg::ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        v_reg       <= v_next;
        res_pos_reg <= res_pos_next;
        res_inr_reg <= res_inr_next;
        res_acc_reg <= res_acc_next;
        if (mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (out_load)
        begin
            position_reg <= res_pos_reg;
            in_range_reg <= res_inr_reg;
            accepted_reg <= res_acc_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Shared divider and table store.
    // ---------------------------------------------------------------------
    lmim_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (v_clamped),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    lmim_table
    #(
        .DEPTH (MAX_LEDS)
    )
    u_table
    (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (index),
        .re    (tbl_re),
        .raddr (idx_reg_cmp[ADDR_W-1:0]),
        .rdata (tbl_rdata)
    );

    assign in_ready  = (state_reg == lmim_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign in_range  = in_range_reg;
    assign accepted  = accepted_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_LEDS))
        else $error("table fill exceeds the store depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(in_range_reg && accepted_reg))
        else $error("a result flags both in-range and accepted");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new transaction taken while one is in progress");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == lmim_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

endmodule
